>>> rtl/core/gtd_pkg.sv
// Shared types, constants and fixed-point helpers for the Goertzel tone detector.
`timescale 1ns / 1ps
`default_nettype none
package gtd_pkg;

  localparam int unsigned CoefW   = 32;
  localparam int unsigned WlenW   = 17;
  localparam int unsigned ThrW    = 16;
  localparam int unsigned SampW   = 32;
  localparam int unsigned DcW     = 40;
  localparam int unsigned AccW    = 64;
  localparam int unsigned ProdW   = 128;
  localparam int unsigned ConfW   = 16;
  localparam int unsigned DenW    = AccW + WlenW;
  localparam int unsigned DivW    = DenW + 31;
  localparam int unsigned OutW    = 24;
  localparam int unsigned OutPadW = OutW - ConfW - 1;

  // register indexes on the config port
  localparam logic [1:0] RegCoef = 2'd0;
  localparam logic [1:0] RegWlen = 2'd1;
  localparam logic [1:0] RegThr  = 2'd2;

  localparam logic signed [CoefW-1:0] ResetCoef = 32'sd2074309917;
  localparam logic [WlenW-1:0]        ResetWlen = 17'd192;
  localparam logic [ThrW-1:0]         ResetThr  = 16'd29491;

  localparam logic [16:0]       AlphaQ16  = 17'd64881;
  localparam logic [AccW-1:0]   EnergyMin = 64'd3;
  localparam logic [4:0]        DivTop    = 5'd16;
  localparam logic [ConfW-1:0]  ConfSat   = 16'hFFFF;

  localparam logic signed [DcW-1:0]  DcMax    = {1'b0, {(DcW-1){1'b1}}};
  localparam logic signed [DcW-1:0]  DcMin    = {1'b1, {(DcW-1){1'b0}}};
  localparam logic signed [AccW-1:0] Int64Max = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] Int64Min = {1'b1, {(AccW-1){1'b0}}};
  localparam logic [ProdW-1:0]       RndQ16   = 128'd1 << 15;
  localparam logic [ProdW-1:0]       RndQ30   = 128'd1 << 29;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC,
    ST_REC,
    ST_UPD,
    ST_SQ,
    ST_A1,
    ST_A2,
    ST_T,
    ST_TB,
    ST_B,
    ST_DEN,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } gtd_state_e;

  typedef struct packed {
    logic            start;
    logic [AccW-1:0] a;
    logic [AccW-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] prod;
  } mul_rsp_t;

  function automatic logic [AccW-1:0] mag64(input logic signed [AccW-1:0] v);
    logic [AccW-1:0] u;
    u = v;
    return v[AccW-1] ? (~u + 64'd1) : u;
  endfunction

  // scale a magnitude product back by 16 or 30 bits, round half away, saturate
  function automatic logic signed [AccW-1:0] mulq_fin(input logic [ProdW-1:0] prod,
                                                      input logic neg,
                                                      input logic sh16);
    logic [ProdW-1:0]       rnd;
    logic [ProdW-1:0]       shr;
    logic signed [AccW-1:0] res;
    rnd = prod + (sh16 ? RndQ16 : RndQ30);
    shr = sh16 ? (rnd >> 16) : (rnd >> 30);
    if (shr[ProdW-1:AccW] != '0) begin
      res = neg ? Int64Min : Int64Max;
    end else if (!neg) begin
      res = shr[AccW-1] ? Int64Max : $signed(shr[AccW-1:0]);
    end else if (shr[AccW-1] && (shr[AccW-2:0] != '0)) begin
      res = Int64Min;
    end else begin
      res = -$signed(shr[AccW-1:0]);
    end
    return res;
  endfunction

  function automatic logic signed [AccW-1:0] sat_add64(input logic signed [AccW-1:0] a,
                                                       input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? Int64Min : Int64Max;
    end
    return s[AccW-1:0];
  endfunction

  function automatic logic signed [AccW-1:0] sat_sub64(input logic signed [AccW-1:0] a,
                                                       input logic signed [AccW-1:0] b);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} - {b[AccW-1], b};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? Int64Min : Int64Max;
    end
    return s[AccW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/gtd_mul.sv
// Iterative 64x64 unsigned multiplier built on one 32x32 multiplier and a 128-bit accumulator.
`timescale 1ns / 1ps
`default_nettype none
module gtd_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gtd_pkg::mul_req_t req_i,
  output gtd_pkg::mul_rsp_t      rsp_o
);
  import gtd_pkg::*;

  logic [AccW-1:0]  a_q, b_q;
  logic [63:0]      part_q, part_d;
  logic [ProdW-1:0] acc_q, acc_d, part_shifted;
  logic [1:0]       psh_q, psh_d;
  logic [2:0]       idx_q, idx_d;
  logic             busy_q, busy_d, pv_q, pv_d, done_q, done_d;
  logic [31:0]      a_part, b_part;
  logic             issue;

  // idx bit 0 picks the half of a, bit 1 the half of b
  assign a_part = idx_q[0] ? a_q[63:32] : a_q[31:0];
  assign b_part = idx_q[1] ? b_q[63:32] : b_q[31:0];
  assign issue  = busy_q && !idx_q[2];
  assign part_d = a_part * b_part;

  always_comb begin
    case (psh_q)
      2'd0:    part_shifted = {64'd0, part_q};
      2'd1:    part_shifted = {32'd0, part_q, 32'd0};
      2'd2:    part_shifted = {part_q, 64'd0};
      default: part_shifted = '0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    pv_d   = issue;
    psh_d  = 2'(idx_q[0]) + 2'(idx_q[1]);
    done_d = busy_q && idx_q[2];
    acc_d  = pv_q ? (acc_q + part_shifted) : acc_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
      acc_d  = '0;
    end else if (issue) begin
      idx_d = idx_q + 3'd1;
    end else if (busy_q) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      pv_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      pv_q   <= pv_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      b_q <= req_i.b;
    end
    part_q <= part_d;
    psh_q  <= psh_d;
    acc_q  <= acc_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("gtd_mul: done raised while still busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q && (idx_q == 3'd0))
    else $error("gtd_mul: start did not begin a product");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && idx_q[2] && !req_i.start) |=> done_q && !busy_q)
    else $error("gtd_mul: last partial product not followed by done");

endmodule
`default_nettype wire

>>> rtl/core/goertzel_tone_detector_core.sv
// Goertzel tone detector: DC blocker, Goertzel recursion, energy and windowed confidence.
//
// Channel  Dir  Handshake                  Payload
// s_axis   in   tvalid/tready              tdata[31:0]: sample
// m_axis   out  tvalid/tready              tlast: window_done; tdata[23:0]: tone_present, confidence
// cfg      in   cfg_we_i (no wait)         cfg_idx_i, cfg_data_i: coefficient/window_length/threshold
//
// A sample that does not close a window is finished before the next one is accepted; one that
// closes a window also runs the power, denominator and divide steps (a saturated confidence skips the bit steps).
// Each 64x64 product runs on the single shared 32x32 multiplier; the
// confidence divide runs one quotient bit a cycle.
// Reset clears all filter and window state and loads the register defaults.
// A result waits in the output register; the next sample is accepted meanwhile, and
// the sequencer holds in its last step only while that register is still full.
`timescale 1ns / 1ps
`default_nettype none
module goertzel_tone_detector_core #(
  parameter int unsigned MAX_WINDOW  = 65536,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] sample
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [23:0] m_axis_tdata,   // [0] tone_present, [16:1] confidence, [23:17] zero
  output      logic        m_axis_tlast,   // window_done
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import gtd_pkg::*;

  localparam int unsigned DropW = SampW - SAMPLE_BITS;
  localparam int unsigned CntW  = (MAX_WINDOW > 131071) ? WlenW : $clog2(MAX_WINDOW + 1);

  gtd_state_e state_q, state_d;

  // configuration
  logic signed [CoefW-1:0] coef_q, coef_d;
  logic [WlenW-1:0]        wlen_q, wlen_d;
  logic [ThrW-1:0]         thr_q, thr_d;

  // filter and window state
  logic [SAMPLE_BITS-1:0]  dc_in_q, dc_in_d;
  logic signed [DcW-1:0]   dc_out_q, dc_out_d;
  logic signed [AccW-1:0]  s1_q, s1_d, s2_q, s2_d;
  logic [AccW-1:0]         energy_q, energy_d;
  logic [CntW-1:0]         count_q, count_d;
  logic                    tone_q, tone_d;
  logic [ConfW-1:0]        conf_q, conf_d;

  // working registers
  logic [SAMPLE_BITS-1:0]  x_q, x_d;
  logic signed [DcW-1:0]   y_q, y_d;
  logic signed [AccW-1:0]  t_q, t_d;
  logic [ProdW-1:0]        pacc_q, pacc_d, p_q, p_d;
  logic                    pz_q, pz_d, wdone_q, wdone_d;
  logic [DivW-1:0]         d_q, d_d;
  logic [ConfW-1:0]        q_q, q_d;
  logic [4:0]              div_i_q, div_i_d;

  // output register
  logic                    ov_q, ov_d, olast_q, olast_d, otone_q, otone_d;
  logic [ConfW-1:0]        oconf_q, oconf_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  gtd_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // DC blocker datapath
  logic signed [SampW-1:0] x_full, dc_in_full;
  logic signed [AccW-1:0]  dc_ta;
  logic signed [41:0]      dc_diff;
  logic [41:0]             y_sum;
  logic signed [DcW-1:0]   y_new;

  assign x_full     = $signed(SampW'($signed(x_q))) <<< DropW;
  assign dc_in_full = $signed(SampW'($signed(dc_in_q))) <<< DropW;
  assign dc_ta      = mulq_fin(mul_rsp.prod, dc_out_q[DcW-1], 1'b1);
  assign dc_diff    = 42'(x_full) - 42'(dc_in_full);
  assign y_sum      = dc_diff + dc_ta[41:0];

  always_comb begin
    if (y_sum[41:39] != {3{y_sum[41]}}) begin
      y_new = y_sum[41] ? DcMin : DcMax;
    end else begin
      y_new = $signed(y_sum[DcW-1:0]);
    end
  end

  logic signed [AccW-1:0] dc_out_ext, y_ext, coef_ext, rec_t;
  assign dc_out_ext = {{(AccW-DcW){dc_out_q[DcW-1]}}, dc_out_q};
  assign y_ext      = {{(AccW-DcW){y_q[DcW-1]}}, y_q};
  assign coef_ext   = {{(AccW-CoefW){coef_q[CoefW-1]}}, coef_q};
  assign rec_t      = mulq_fin(mul_rsp.prod, coef_q[CoefW-1] ^ s1_q[AccW-1], 1'b0);

  // energy update, saturating
  logic              sq_hi;
  logic [AccW:0]     e_sum;
  logic [AccW-1:0]   energy_new;
  assign sq_hi      = |mul_rsp.prod[ProdW-1:95];
  assign e_sum      = {1'b0, energy_q} + {1'b0, mul_rsp.prod[94:31]};
  assign energy_new = (sq_hi || e_sum[AccW]) ? '1 : e_sum[AccW-1:0];

  // window limit and count
  logic [CntW-1:0] limit, count_n;
  logic            wl_over, win_end;
  assign wl_over = 32'(wlen_q) > 32'(MAX_WINDOW);
  assign limit   = wl_over ? CntW'(MAX_WINDOW) : CntW'(wlen_q);
  assign count_n = count_q + CntW'(1);
  assign win_end = count_n >= limit;

  // power: a +/- b on one adder, carry out tells a >= b when subtracting
  logic             bneg;
  logic [ProdW-1:0] b_add;
  logic [ProdW:0]   pw_sum;
  assign bneg   = t_q[AccW-1] ^ s2_q[AccW-1];
  assign b_add  = bneg ? mul_rsp.prod : ~mul_rsp.prod;
  assign pw_sum = {1'b0, pacc_q} + {1'b0, b_add} + {{ProdW{1'b0}}, !bneg};

  // restoring divide step
  logic [ProdW:0] div_diff;
  logic           div_ge;
  assign div_diff = {1'b0, p_q} - {{(ProdW-DivW+1){1'b0}}, d_q};
  assign div_ge   = !div_diff[ProdW];

  logic [ConfW-1:0] conf_fin;
  assign conf_fin = ((energy_q < EnergyMin) || pz_q) ? '0 : q_q;

  always_comb begin
    state_d  = state_q;
    coef_d   = coef_q;
    wlen_d   = wlen_q;
    thr_d    = thr_q;
    dc_in_d  = dc_in_q;
    dc_out_d = dc_out_q;
    s1_d     = s1_q;
    s2_d     = s2_q;
    energy_d = energy_q;
    count_d  = count_q;
    tone_d   = tone_q;
    conf_d   = conf_q;
    x_d      = x_q;
    y_d      = y_q;
    t_d      = t_q;
    pacc_d   = pacc_q;
    p_d      = p_q;
    pz_d     = pz_q;
    wdone_d  = wdone_q;
    d_d      = d_q;
    q_d      = q_q;
    div_i_d  = div_i_q;
    ov_d     = ov_q && !m_axis_tready;
    olast_d  = olast_q;
    otone_d  = otone_q;
    oconf_d  = oconf_q;
    mul_req  = '0;
    s_axis_tready = 1'b0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegCoef: coef_d = $signed(cfg_data_i[CoefW-1:0]);
        RegWlen: wlen_d = cfg_data_i[WlenW-1:0];
        RegThr:  thr_d  = cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          x_d           = s_axis_tdata[SampW-1 -: SAMPLE_BITS];
          mul_req.start = 1'b1;
          mul_req.a     = mag64(dc_out_ext);
          mul_req.b     = 64'(AlphaQ16);
          state_d       = ST_DC;
        end
      end
      ST_DC: begin
        if (mul_rsp.done) begin
          dc_in_d       = x_q;
          dc_out_d      = y_new;
          y_d           = y_new;
          mul_req.start = 1'b1;
          mul_req.a     = mag64(coef_ext);
          mul_req.b     = mag64(s1_q);
          state_d       = ST_REC;
        end
      end
      ST_REC: begin
        if (mul_rsp.done) begin
          t_d     = rec_t;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        s1_d          = sat_sub64(sat_add64(y_ext, t_q), s2_q);
        s2_d          = s1_q;
        mul_req.start = 1'b1;
        mul_req.a     = mag64(y_ext);
        mul_req.b     = mag64(y_ext);
        state_d       = ST_SQ;
      end
      ST_SQ: begin
        if (mul_rsp.done) begin
          energy_d = energy_new;
          count_d  = count_n;
          wdone_d  = win_end;
          if (win_end) begin
            mul_req.start = 1'b1;
            mul_req.a     = mag64(s1_q);
            mul_req.b     = mag64(s1_q);
            state_d       = ST_A1;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_A1: begin
        if (mul_rsp.done) begin
          pacc_d        = mul_rsp.prod;
          mul_req.start = 1'b1;
          mul_req.a     = mag64(s2_q);
          mul_req.b     = mag64(s2_q);
          state_d       = ST_A2;
        end
      end
      ST_A2: begin
        if (mul_rsp.done) begin
          pacc_d        = pacc_q + mul_rsp.prod;
          mul_req.start = 1'b1;
          mul_req.a     = mag64(coef_ext);
          mul_req.b     = mag64(s1_q);
          state_d       = ST_T;
        end
      end
      ST_T: begin
        if (mul_rsp.done) begin
          t_d     = rec_t;
          state_d = ST_TB;
        end
      end
      ST_TB: begin
        mul_req.start = 1'b1;
        mul_req.a     = mag64(t_q);
        mul_req.b     = mag64(s2_q);
        state_d       = ST_B;
      end
      ST_B: begin
        if (mul_rsp.done) begin
          p_d           = pw_sum[ProdW-1:0];
          pz_d          = !bneg && !pw_sum[ProdW];
          mul_req.start = 1'b1;
          mul_req.a     = energy_q;
          mul_req.b     = 64'(count_q);
          state_d       = ST_DEN;
        end
      end
      ST_DEN: begin
        if (mul_rsp.done) begin
          // divisor starts at den << 31 for the saturation check
          d_d     = {mul_rsp.prod[DenW-1:0], 31'd0};
          div_i_d = DivTop;
          q_d     = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        d_d = d_q >> 1;
        if (div_i_q == DivTop) begin
          div_i_d = div_i_q - 5'd1;
          if (div_ge) begin
            q_d     = ConfSat;
            state_d = ST_FIN;
          end
        end else begin
          q_d = {q_q[ConfW-2:0], div_ge};
          if (div_ge) begin
            p_d = div_diff[ProdW-1:0];
          end
          if (div_i_q == '0) begin
            state_d = ST_FIN;
          end else begin
            div_i_d = div_i_q - 5'd1;
          end
        end
      end
      ST_FIN: begin
        conf_d   = conf_fin;
        tone_d   = conf_fin > thr_q;
        s1_d     = '0;
        s2_d     = '0;
        energy_d = '0;
        count_d  = '0;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_q || m_axis_tready) begin
          ov_d    = 1'b1;
          olast_d = wdone_q;
          otone_d = tone_q;
          oconf_d = conf_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      coef_q   <= ResetCoef;
      wlen_q   <= ResetWlen;
      thr_q    <= ResetThr;
      dc_in_q  <= '0;
      dc_out_q <= '0;
      s1_q     <= '0;
      s2_q     <= '0;
      energy_q <= '0;
      count_q  <= '0;
      tone_q   <= 1'b0;
      conf_q   <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      coef_q   <= coef_d;
      wlen_q   <= wlen_d;
      thr_q    <= thr_d;
      dc_in_q  <= dc_in_d;
      dc_out_q <= dc_out_d;
      s1_q     <= s1_d;
      s2_q     <= s2_d;
      energy_q <= energy_d;
      count_q  <= count_d;
      tone_q   <= tone_d;
      conf_q   <= conf_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    y_q     <= y_d;
    t_q     <= t_d;
    pacc_q  <= pacc_d;
    p_q     <= p_d;
    pz_q    <= pz_d;
    wdone_q <= wdone_d;
    d_q     <= d_d;
    q_q     <= q_d;
    div_i_q <= div_i_d;
    olast_q <= olast_d;
    otone_q <= otone_d;
    oconf_q <= oconf_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{OutPadW{1'b0}}, oconf_q, otone_q};

  a_mul_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp.done |-> (state_q == ST_DC || state_q == ST_REC || state_q == ST_SQ ||
                      state_q == ST_A1 || state_q == ST_A2 || state_q == ST_T ||
                      state_q == ST_B || state_q == ST_DEN))
    else $error("product finished outside a waiting step");

  a_window_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) |=> (energy_q == '0 && count_q == '0 && s1_q == '0 && s2_q == '0))
    else $error("window state not cleared after window end");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && ov_q && !m_axis_tready) |=> (state_q == ST_OUT && ov_q))
    else $error("result left before the output register was free");

endmodule
`default_nettype wire
